FILE: design/e2q_pkg.sv
// ----------------------------------------------------------------------------
// e2q_pkg: shared types and constants for the Euler to quaternion converter
// Fixed-point formats, series divisors and pipeline depths.
// ----------------------------------------------------------------------------
`default_nettype none

package e2q_pkg;

	// Q30 unity and pi in Q31
	localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
	localparam logic [32:0] PI_Q31  = 33'd6746518852;

	// widths of the fixed-point values
	localparam int X_W   = 31;  // half angle in radians, Q30
	localparam int X2_W  = 32;  // squared half angle, Q30
	localparam int T_W   = 31;  // series term, 0 .. ONE
	localparam int SIN_W = 32;  // signed sine, Q30
	localparam int DIV_W = 9;   // series divisor

	// series divisors, first cell first
	localparam int SIN_STAGES = 8;
	localparam int COS_STAGES = 9;
	localparam int unsigned SIN_DIV [SIN_STAGES] = '{272, 210, 156, 110, 72, 42, 20, 6};
	localparam int unsigned COS_DIV [COS_STAGES] = '{306, 240, 182, 132, 90, 56, 30, 12, 2};

	// pipeline depths in register stages
	localparam int CELL_LAT = 3;
	localparam int SIN_DLY  = CELL_LAT * SIN_STAGES;
	localparam int HALF_LAT = 2 + CELL_LAT * COS_STAGES;
	localparam int QUAT_LAT = 4;

	// sine and cosine of one half angle
	typedef struct packed {
		logic signed [SIN_W-1:0] s;
		logic [T_W-1:0]          c;
	} sincos_t;

endpackage

`default_nettype wire

FILE: design/e2q_cell.sv
// ----------------------------------------------------------------------------
// e2q_cell: one series cell
// Maps t to ONE - ((x2*t >> 30) / K) held at zero, in three stages, and
// hands x2 on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module e2q_cell #(
	parameter int unsigned K = 2
) (
	input  wire logic                      clk,
	input  wire logic                      ce,
	input  wire logic [e2q_pkg::X2_W-1:0]  x2_in,
	input  wire logic [e2q_pkg::T_W-1:0]   t_in,
	output logic      [e2q_pkg::X2_W-1:0]  x2_out,
	output logic      [e2q_pkg::T_W-1:0]   t_out
);
	import e2q_pkg::*;

	localparam logic [DIV_W-1:0] K_V   = DIV_W'(K);
	localparam logic [31:0]      RECIP = 32'((64'd1 << 32) / K);

	logic [62:0] prod;
	logic [63:0] qprod;
	logic [40:0] qk;
	logic [40:0] rem;
	logic        bump;
	logic [31:0] sub;

	logic [X2_W-1:0] x2_s1, x2_s2, x2_s3;
	logic [31:0]     n_s1, n_s2;
	logic [31:0]     q_s2;
	logic [T_W-1:0]  t_s3;

	// product with the squared angle, estimate of the quotient, correction
	always_comb begin
		prod  = 63'(x2_in) * 63'(t_in);
		qprod = 64'(n_s1) * 64'(RECIP);
		qk    = 41'(q_s2) * 41'(K_V);
		rem   = 41'(n_s2) - qk;
		bump  = rem >= 41'(K_V);
		sub   = q_s2 + 32'(bump);
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			x2_s1 <= x2_in;
			n_s1  <= prod[61:30];
			x2_s2 <= x2_s1;
			n_s2  <= n_s1;
			q_s2  <= qprod[63:32];
			x2_s3 <= x2_s2;
			t_s3  <= (sub >= ONE_Q30) ? '0 : T_W'(ONE_Q30 - sub);
		end
	end

	assign x2_out = x2_s3;
	assign t_out  = t_s3;

endmodule

`default_nettype wire

FILE: design/e2q_half.sv
// ----------------------------------------------------------------------------
// e2q_half: sine and cosine of half a binary angle
// Scales the angle to radians, squares it and runs two chains of series
// cells, one for the sine and one for the cosine.
// ----------------------------------------------------------------------------
`default_nettype none

module e2q_half #(
	parameter int ANGLE_WIDTH = 16
) (
	input  wire logic                    clk,
	input  wire logic                    ce,
	input  wire logic [ANGLE_WIDTH-1:0]  angle,
	output e2q_pkg::sincos_t             sc
);
	import e2q_pkg::*;

	localparam int AW = ANGLE_WIDTH;

	typedef struct packed {
		logic           neg;
		logic [X_W-1:0] x;
	} side_t;

	logic           neg;
	logic [AW-1:0]  m;
	logic [AW+32:0] prod;
	logic [61:0]    sq;
	logic [61:0]    pf;

	logic           neg_s1, neg_s2;
	logic [X_W-1:0] x_s1, x_s2;
	logic [X2_W-1:0] x2_s2;
	side_t          side_q [SIN_DLY];

	logic [X2_W-1:0] sin_x2 [SIN_STAGES+1];
	logic [T_W-1:0]  sin_t  [SIN_STAGES+1];
	logic [X2_W-1:0] cos_x2 [COS_STAGES+1];
	logic [T_W-1:0]  cos_t  [COS_STAGES+1];

	logic             fneg_s1, fneg_s2;
	logic [31:0]      pm_s1;
	logic [T_W-1:0]   mag_s2;
	logic signed [SIN_W-1:0] sin_s3;

	// magnitude of the angle and its scaling to radians, Q30
	always_comb begin
		neg  = angle[AW-1];
		m    = neg ? (AW'(~angle) + AW'(1)) : angle;
		prod = (AW+33)'(m) * (AW+33)'(PI_Q31);
		sq   = 62'(x_s1) * 62'(x_s1);
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			neg_s1 <= neg;
			x_s1   <= prod[AW+31:AW+1];
			neg_s2 <= neg_s1;
			x_s2   <= x_s1;
			x2_s2  <= sq[61:30];
		end
	end

	// angle and sign travel beside the sine chain
	always_ff @(posedge clk) begin
		if (ce) begin
			side_q[0] <= '{neg: neg_s2, x: x_s2};
			for (int i = 1; i < SIN_DLY; i++) begin
				side_q[i] <= side_q[i-1];
			end
		end
	end

	// sine series chain
	assign sin_x2[0] = x2_s2;
	assign sin_t[0]  = T_W'(ONE_Q30);

	for (genvar i = 0; i < SIN_STAGES; i++) begin : g_sin
		e2q_cell #(
			.K (SIN_DIV[i])
		) u_cell (
			.clk    (clk),
			.ce     (ce),
			.x2_in  (sin_x2[i]),
			.t_in   (sin_t[i]),
			.x2_out (sin_x2[i+1]),
			.t_out  (sin_t[i+1])
		);
	end

	// cosine series chain
	assign cos_x2[0] = x2_s2;
	assign cos_t[0]  = T_W'(ONE_Q30);

	for (genvar i = 0; i < COS_STAGES; i++) begin : g_cos
		e2q_cell #(
			.K (COS_DIV[i])
		) u_cell (
			.clk    (clk),
			.ce     (ce),
			.x2_in  (cos_x2[i]),
			.t_in   (cos_t[i]),
			.x2_out (cos_x2[i+1]),
			.t_out  (cos_t[i+1])
		);
	end

	// sine finish: times x, hold at one, apply sign
	assign pf = 62'(side_q[SIN_DLY-1].x) * 62'(sin_t[SIN_STAGES]);

	always_ff @(posedge clk) begin
		if (ce) begin
			fneg_s1 <= side_q[SIN_DLY-1].neg;
			pm_s1   <= pf[61:30];
			fneg_s2 <= fneg_s1;
			mag_s2  <= (pm_s1 > ONE_Q30) ? T_W'(ONE_Q30) : pm_s1[T_W-1:0];
			sin_s3  <= fneg_s2 ? -$signed({1'b0, mag_s2}) : $signed({1'b0, mag_s2});
		end
	end

	assign sc.s = sin_s3;
	assign sc.c = cos_t[COS_STAGES];

endmodule

`default_nettype wire

FILE: design/e2q_quat.sv
// ----------------------------------------------------------------------------
// e2q_quat: quaternion products
// Forms the eight triple products of the half-angle sines and cosines,
// combines them into w, x, y, z, rounds and saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module e2q_quat #(
	parameter int QUAT_WIDTH = 16
) (
	input  wire logic                   clk,
	input  wire logic                   ce,
	input  wire e2q_pkg::sincos_t       roll,
	input  wire e2q_pkg::sincos_t       pitch,
	input  wire e2q_pkg::sincos_t       yaw,
	output logic [QUAT_WIDTH-1:0]       quat_w,
	output logic [QUAT_WIDTH-1:0]       quat_x,
	output logic [QUAT_WIDTH-1:0]       quat_y,
	output logic [QUAT_WIDTH-1:0]       quat_z
);
	import e2q_pkg::*;

	localparam int QW = QUAT_WIDTH;
	localparam int SH = (QW >= 32) ? 0 : 31 - QW;
	localparam logic signed [34:0] RND = 35'((64'd1 << SH) >> 1);
	localparam logic signed [34:0] HI  = 35'((64'd1 << (QW - 1)) - 1);
	localparam logic signed [34:0] LO  = -HI - 35'sd1;

	// index bits of a triple: roll, pitch, yaw; 1 picks the sine
	localparam int T_CCC = 0, T_CCS = 1, T_CSC = 2, T_CSS = 3;
	localparam int T_SCC = 4, T_SCS = 5, T_SSC = 6, T_SSS = 7;

	logic [T_W-1:0] rm [2];
	logic [T_W-1:0] pm [2];
	logic [T_W-1:0] ym [2];
	logic [61:0]    rp_prod  [4];
	logic [61:0]    tri_prod [8];
	logic signed [32:0] tri_v [8];
	logic signed [34:0] ext  [4];
	logic signed [34:0] rnd  [4];

	logic [2:0]     sgn_s1, sgn_s2;
	logic [T_W-1:0] rp_s1  [4];
	logic [T_W-1:0] ym_s1  [2];
	logic [T_W-1:0] tri_s2 [8];
	logic signed [32:0] sum_s3 [4];
	logic [QW-1:0]  out_s4 [4];

	// magnitudes of the factors and the roll-pitch products
	always_comb begin
		rm[0] = roll.c;
		rm[1] = roll.s[SIN_W-1] ? T_W'(-roll.s) : T_W'(roll.s);
		pm[0] = pitch.c;
		pm[1] = pitch.s[SIN_W-1] ? T_W'(-pitch.s) : T_W'(pitch.s);
		ym[0] = yaw.c;
		ym[1] = yaw.s[SIN_W-1] ? T_W'(-yaw.s) : T_W'(yaw.s);
		for (int i = 0; i < 4; i++) begin
			rp_prod[i] = 62'(rm[i/2]) * 62'(pm[i%2]);
		end
		for (int i = 0; i < 8; i++) begin
			tri_prod[i] = 62'(rp_s1[i/2]) * 62'(ym_s1[i%2]);
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			sgn_s1 <= {roll.s[SIN_W-1], pitch.s[SIN_W-1], yaw.s[SIN_W-1]};
			for (int i = 0; i < 4; i++) begin
				rp_s1[i] <= rp_prod[i][60:30];
			end
			ym_s1[0] <= ym[0];
			ym_s1[1] <= ym[1];
			sgn_s2   <= sgn_s1;
			for (int i = 0; i < 8; i++) begin
				tri_s2[i] <= tri_prod[i][60:30];
			end
		end
	end

	// signed triples: negative when an odd count of sine factors is negative
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			tri_v[i] = (^(sgn_s2 & 3'(i))) ? -$signed({2'b00, tri_s2[i]})
			                               :  $signed({2'b00, tri_s2[i]});
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			sum_s3[0] <= tri_v[T_CCC] + tri_v[T_SSS];
			sum_s3[1] <= tri_v[T_SCC] - tri_v[T_CSS];
			sum_s3[2] <= tri_v[T_CSC] + tri_v[T_SCS];
			sum_s3[3] <= tri_v[T_CCS] - tri_v[T_SSC];
		end
	end

	// round half up to the output fraction and saturate
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			ext[i] = 35'(sum_s3[i]);
			rnd[i] = (QW >= 32) ? (ext[i] <<< 1) : ((ext[i] + RND) >>> SH);
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < 4; i++) begin
				if (rnd[i] > HI) begin
					out_s4[i] <= HI[QW-1:0];
				end else if (rnd[i] < LO) begin
					out_s4[i] <= LO[QW-1:0];
				end else begin
					out_s4[i] <= rnd[i][QW-1:0];
				end
			end
		end
	end

	assign quat_w = out_s4[0];
	assign quat_x = out_s4[1];
	assign quat_y = out_s4[2];
	assign quat_z = out_s4[3];

endmodule

`default_nettype wire

FILE: design/euler_to_quaternion.sv
// ----------------------------------------------------------------------------
// euler_to_quaternion: ZYX Euler angles to unit quaternion
// Input stream: one transaction carries roll, pitch and yaw as signed binary
// angles (full scale is plus or minus pi). Output stream: one transaction
// per input with w, x, y, z as signed Q1.(QUAT_WIDTH-1), saturated.
// Each angle is halved and its sine and cosine come from two chains of
// series cells (eight for the sine, nine for the cosine), each cell three
// register stages; the products and the rounding follow.
// Input path: input register, half-angle stages, products, output register.
// Throughput: one transaction per cycle; every stage holds one sample.
// Stall: while m_tvalid is high and m_tready low the whole pipeline holds
// and s_tready is low; bubbles move on whenever the output slot is free.
// Reset clears the valid bits only; the block keeps no state between
// samples.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_to_quaternion #(
	parameter int ANGLE_WIDTH = 16,
	parameter int QUAT_WIDTH  = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// input stream
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	// tdata, low bit up: roll_angle, pitch_angle, yaw_angle, zero fill
	input  wire logic [((3*ANGLE_WIDTH+7)/8)*8-1:0]     s_tdata,
	// output stream
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	// tdata, low bit up: quat_w, quat_x, quat_y, quat_z, zero fill
	output logic [((4*QUAT_WIDTH+7)/8)*8-1:0]           m_tdata
);
	import e2q_pkg::*;

	localparam int AW    = ANGLE_WIDTH;
	localparam int QW    = QUAT_WIDTH;
	localparam int OUT_W = ((4*QW+7)/8)*8;
	localparam int LAT   = 1 + HALF_LAT + QUAT_LAT;

	logic          ce;
	logic [LAT-1:0] vld_q;
	logic [AW-1:0] roll_s0, pitch_s0, yaw_s0;
	sincos_t       roll_sc, pitch_sc, yaw_sc;
	logic [QW-1:0] quat_w, quat_x, quat_y, quat_z;

	// the pipeline moves whenever the output slot is empty or being taken
	assign ce       = !vld_q[LAT-1] || m_tready;
	assign s_tready = ce;
	assign m_tvalid = vld_q[LAT-1];

	// valid bit per stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ce) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (ce) begin
			roll_s0  <= s_tdata[AW-1:0];
			pitch_s0 <= s_tdata[2*AW-1:AW];
			yaw_s0   <= s_tdata[3*AW-1:2*AW];
		end
	end

	// half-angle sine and cosine per axis
	e2q_half #(
		.ANGLE_WIDTH (AW)
	) u_half_roll (
		.clk   (clk),
		.ce    (ce),
		.angle (roll_s0),
		.sc    (roll_sc)
	);

	e2q_half #(
		.ANGLE_WIDTH (AW)
	) u_half_pitch (
		.clk   (clk),
		.ce    (ce),
		.angle (pitch_s0),
		.sc    (pitch_sc)
	);

	e2q_half #(
		.ANGLE_WIDTH (AW)
	) u_half_yaw (
		.clk   (clk),
		.ce    (ce),
		.angle (yaw_s0),
		.sc    (yaw_sc)
	);

	// products, rounding and output register
	e2q_quat #(
		.QUAT_WIDTH (QW)
	) u_quat (
		.clk    (clk),
		.ce     (ce),
		.roll   (roll_sc),
		.pitch  (pitch_sc),
		.yaw    (yaw_sc),
		.quat_w (quat_w),
		.quat_x (quat_x),
		.quat_y (quat_y),
		.quat_z (quat_z)
	);

	assign m_tdata = OUT_W'({quat_z, quat_y, quat_x, quat_w});

endmodule

`default_nettype wire

FILE: sim/quat_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quat_checker: prediction and comparison for euler_to_quaternion
// Watches both stream channels. Every input transaction is turned into the
// expected quaternion by a bit-exact fixed-point model of the converter.
// Every output transaction is compared field by field with the oldest
// expected quaternion. Mismatches and the count of open expectations are
// handed to the testbench top.
// ----------------------------------------------------------------------------

module quat_checker #(
	parameter int ANGLE_WIDTH = 16,
	parameter int QUAT_WIDTH  = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	input  logic                                   s_tready,
	// roll_angle, pitch_angle, yaw_angle, zero fill
	input  logic [((3*ANGLE_WIDTH+7)/8)*8-1:0]     s_tdata,
	input  logic                                   m_tvalid,
	input  logic                                   m_tready,
	// quat_w, quat_x, quat_y, quat_z, zero fill
	input  logic [((4*QUAT_WIDTH+7)/8)*8-1:0]      m_tdata,
	output int                                     mismatches,
	output int                                     outstanding
);

	localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
	localparam logic [63:0] PI_Q31  = 64'd6746518852;
	localparam int          N_SIN   = 8;
	localparam int          N_COS   = 9;
	localparam logic [63:0] SIN_K [N_SIN] = '{64'd272, 64'd210, 64'd156, 64'd110,
		64'd72, 64'd42, 64'd20, 64'd6};
	localparam logic [63:0] COS_K [N_COS] = '{64'd306, 64'd240, 64'd182, 64'd132,
		64'd90, 64'd56, 64'd30, 64'd12, 64'd2};

	// first field in the low bits
	typedef struct packed {
		logic signed [ANGLE_WIDTH-1:0] yaw;
		logic signed [ANGLE_WIDTH-1:0] pitch;
		logic signed [ANGLE_WIDTH-1:0] roll;
	} euler_t;

	typedef struct packed {
		logic signed [QUAT_WIDTH-1:0] z;
		logic signed [QUAT_WIDTH-1:0] y;
		logic signed [QUAT_WIDTH-1:0] x;
		logic signed [QUAT_WIDTH-1:0] w;
	} quat_t;

	// sine and cosine of a half angle, Q30
	typedef struct packed {
		longint s;
		longint c;
	} half_trig_t;

	quat_t quat_expected [$];
	int    bad_count = 0;

	// one term of the nested series: 1 - x2*t/k, floored at zero
	function automatic logic [63:0] series_cell(input logic [63:0] x2, t, k);
		logic [63:0] sub;
		sub = ((x2 * t) >> 30) / k;
		return (sub >= ONE_Q30) ? 64'd0 : ONE_Q30 - sub;
	endfunction

	function automatic half_trig_t half_trig(input logic signed [ANGLE_WIDTH-1:0] ang);
		longint      a;
		logic [63:0] u, x, x2, t;
		half_trig_t  r;
		a = longint'(ang);
		u = (a < 0) ? -a : a;
		u = u << (32 - ANGLE_WIDTH);
		x = (u * PI_Q31) >> 33;
		x2 = (x * x) >> 30;
		t = ONE_Q30;
		for (int i = 0; i < N_SIN; i++)
			t = series_cell(x2, t, SIN_K[i]);
		t = (x * t) >> 30;
		if (t > ONE_Q30)
			t = ONE_Q30;
		r.s = t;
		if (a < 0)
			r.s = -r.s;
		t = ONE_Q30;
		for (int i = 0; i < N_COS; i++)
			t = series_cell(x2, t, COS_K[i]);
		r.c = t;
		return r;
	endfunction

	// product of three Q30 values on magnitudes, sign applied last
	function automatic longint triple_prod(input longint p, q, r);
		logic [63:0] ap, aq, ar, mag;
		int          negs;
		negs = int'(p < 0) + int'(q < 0) + int'(r < 0);
		ap = (p < 0) ? -p : p;
		aq = (q < 0) ? -q : q;
		ar = (r < 0) ? -r : r;
		mag = (((ap * aq) >> 30) * ar) >> 30;
		return (negs % 2 == 1) ? -longint'(mag) : longint'(mag);
	endfunction

	// Q30 to Q1.(QUAT_WIDTH-1), round half up, saturate
	function automatic logic [QUAT_WIDTH-1:0] round_sat(input longint v);
		longint hi, lo, r, bias;
		int     sh;
		hi = (longint'(1) << (QUAT_WIDTH - 1)) - 1;
		lo = -(longint'(1) << (QUAT_WIDTH - 1));
		if (QUAT_WIDTH >= 32) begin
			r = v * 2;
		end else begin
			sh = 31 - QUAT_WIDTH;
			bias = longint'(1) << 33;
			r = v + bias;
			if (sh > 0)
				r = r + (longint'(1) << (sh - 1));
			r = (r >>> sh) - (bias >>> sh);
		end
		if (r > hi)
			r = hi;
		if (r < lo)
			r = lo;
		return r[QUAT_WIDTH-1:0];
	endfunction

	function automatic quat_t quat_from_euler(input euler_t e);
		half_trig_t r, p, y;
		quat_t      q;
		r = half_trig(e.roll);
		p = half_trig(e.pitch);
		y = half_trig(e.yaw);
		q.w = round_sat(triple_prod(r.c, p.c, y.c) + triple_prod(r.s, p.s, y.s));
		q.x = round_sat(triple_prod(r.s, p.c, y.c) - triple_prod(r.c, p.s, y.s));
		q.y = round_sat(triple_prod(r.c, p.s, y.c) + triple_prod(r.s, p.c, y.s));
		q.z = round_sat(triple_prod(r.c, p.c, y.s) - triple_prod(r.s, p.s, y.c));
		return q;
	endfunction

	function automatic int field_diff(input string name,
		input logic signed [QUAT_WIDTH-1:0] want, got);
		if (want === got)
			return 0;
		$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		return 1;
	endfunction

	// output side first so a result can never meet its own expectation early
	always @(posedge clk) begin
		quat_t got, want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = quat_t'(m_tdata[4*QUAT_WIDTH-1:0]);
				if (quat_expected.size() == 0) begin
					$display("%0t: expected no transaction, got w=%0d x=%0d y=%0d z=%0d",
						$time, got.w, got.x, got.y, got.z);
					bad_count++;
				end else begin
					want = quat_expected.pop_front();
					bad_count += field_diff("quat_w", want.w, got.w);
					bad_count += field_diff("quat_x", want.x, got.x);
					bad_count += field_diff("quat_y", want.y, got.y);
					bad_count += field_diff("quat_z", want.z, got.z);
				end
			end
			if (s_tvalid && s_tready)
				quat_expected.push_back(quat_from_euler(euler_t'(s_tdata[3*ANGLE_WIDTH-1:0])));
		end
		mismatches <= bad_count;
		outstanding <= quat_expected.size();
	end

endmodule

FILE: sim/euler_to_quaternion_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// euler_to_quaternion_tb: stream test of the Euler to quaternion converter
// Sends a directed set of angle triples (zero, plus and minus pi, the
// quarter turns, alternating bit patterns) and then random triples biased
// toward the angle extremes, with random gaps on the input side and random
// stalls on the output side, plus one long output hold-off that backs the
// pipeline up. quat_checker predicts and compares every transaction.
// ----------------------------------------------------------------------------

module euler_to_quaternion_tb;

	localparam int ANGLE_WIDTH    = 16;
	localparam int QUAT_WIDTH     = 16;
	localparam int S_W            = ((3*ANGLE_WIDTH+7)/8)*8;
	localparam int M_W            = ((4*QUAT_WIDTH+7)/8)*8;
	localparam int RANDOM_ITEMS   = 1300;
	localparam int BACKLOG_AT     = 400;
	localparam int BACKLOG_CYCLES = 300;
	localparam int DRAIN_CYCLES   = 60;
	localparam int CYCLE_LIMIT    = 400000;

	// roll, pitch, yaw from the top down
	localparam int N_DIR = 22;
	localparam logic [47:0] DIRECTED [N_DIR] = '{
		48'h0000_0000_0000, 48'h8000_0000_0000, 48'h0000_8000_0000,
		48'h0000_0000_8000, 48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF,
		48'h7FFF_0000_0000, 48'h0001_0001_0001, 48'hFFFF_FFFF_FFFF,
		48'h4000_0000_0000, 48'h0000_4000_0000, 48'h0000_0000_4000,
		48'hC000_4000_C000, 48'h8001_7FFF_8000, 48'h2000_E000_2000,
		48'h5555_AAAA_5555, 48'hAAAA_5555_AAAA, 48'h0000_8000_7FFF,
		48'h7FFF_0000_8000, 48'h4000_4000_4000, 48'hFFFF_8000_0001,
		48'h1234_EDCB_0F0F
	};

	logic           clk;
	logic           arst_n;
	logic           s_tvalid;
	logic           s_tready;
	logic [S_W-1:0] s_tdata;
	logic           m_tvalid;
	logic           m_tready;
	logic [M_W-1:0] m_tdata;

	int mismatches;
	int outstanding;
	int cycle_count = 0;
	int src_mode    = 0;
	bit backlog_req = 1'b0;

	euler_to_quaternion #(
		.ANGLE_WIDTH(ANGLE_WIDTH),
		.QUAT_WIDTH (QUAT_WIDTH)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	quat_checker #(
		.ANGLE_WIDTH(ANGLE_WIDTH),
		.QUAT_WIDTH (QUAT_WIDTH)
	) checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[euler_to_quaternion] ERROR");
			$finish;
		end
	end

	// mostly none, short gaps sometimes, a long one now and then
	function automatic int pick_gap(input int mode);
		case (mode)
			0: return 0;
			1: return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
			default: begin
				if ($urandom_range(0, 19) == 0)
					return $urandom_range(10, 40);
				return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
			end
		endcase
	endfunction

	// uniform most of the time, else near -pi, +pi, zero or a quarter turn
	function automatic logic [ANGLE_WIDTH-1:0] random_angle();
		logic [ANGLE_WIDTH-1:0] a;
		case ($urandom_range(0, 9))
			0: a = ANGLE_WIDTH'(16'h8000 + $urandom_range(0, 3));
			1: a = ANGLE_WIDTH'(16'h7FFF - $urandom_range(0, 3));
			2: a = ANGLE_WIDTH'($urandom_range(0, 4) - 2);
			3: a = ANGLE_WIDTH'((($urandom_range(0, 1) == 0) ? 16'h4000 : 16'hC000)
				+ $urandom_range(0, 6) - 3);
			default: a = ANGLE_WIDTH'($urandom());
		endcase
		return a;
	endfunction

	// offer one transaction and hold it until accepted
	task automatic send_angles(input logic [ANGLE_WIDTH-1:0] roll, pitch, yaw);
		s_tdata <= {yaw, pitch, roll};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic idle_for(input int n);
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// input side
	initial begin : source
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++) begin
			send_angles(DIRECTED[i][47:32], DIRECTED[i][31:16], DIRECTED[i][15:0]);
			idle_for(pick_gap(1));
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 100 == 0)
				src_mode = $urandom_range(0, 2);
			if (i == BACKLOG_AT)
				backlog_req = 1'b1;
			send_angles(random_angle(), random_angle(), random_angle());
			idle_for(pick_gap(src_mode));
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("[euler_to_quaternion] OK");
		else
			$display("[euler_to_quaternion] ERROR");
		$finish;
	end

	// output side: runs of always-ready, light and heavy stalls, long stalls
	initial begin : sink
		int  mode, run_len;
		bit  backlog_done;
		backlog_done = 1'b0;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			mode = $urandom_range(0, 3);
			run_len = $urandom_range(20, 150);
			for (int k = 0; k < run_len; k++) begin
				@(posedge clk);
				// one long hold-off while the source keeps offering
				if (backlog_req && !backlog_done) begin
					backlog_done = 1'b1;
					m_tready <= 1'b0;
					repeat (BACKLOG_CYCLES) @(posedge clk);
				end
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					2: m_tready <= ($urandom_range(0, 1) != 0);
					default: begin
						if ($urandom_range(0, 24) == 0) begin
							m_tready <= 1'b0;
							repeat ($urandom_range(10, 40)) @(posedge clk);
						end else begin
							m_tready <= 1'b1;
						end
					end
				endcase
			end
		end
	end

endmodule
